// File: design/dnle_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the DNS name label encoder.
// No dependencies; used by every module of the block.
package dnle_pkg;

  localparam int LABEL_LIMIT = 64;
  localparam int NAME_LIMIT  = 255;

  localparam int BYTE_W = 8;
  localparam int CELLS  = LABEL_LIMIT - 1;
  localparam int LEN_W  = $clog2(LABEL_LIMIT);
  localparam int WIRE_W = $clog2(NAME_LIMIT + 1);
  localparam int SUM_W  = $clog2(NAME_LIMIT + LABEL_LIMIT + 2);

  localparam logic [BYTE_W-1:0] DOT_CHAR = BYTE_W'(46);

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } opcode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DATA = 1'b1
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [LEN_W-1:0]  wr_idx;
    logic [BYTE_W-1:0] wr_char;
    logic              shift;
  } chain_ctl_t;

endpackage

// File: design/dnle_cell.sv
`timescale 1ns / 1ps
// One label cell: holds a single label character.
// Loads a new character at its own index or takes its neighbor's on shift. Uses dnle_pkg.
module dnle_cell (
  input  logic                             clk,
  input  dnle_pkg::chain_ctl_t             ctl,
  input  logic [dnle_pkg::LEN_W-1:0]       idx,
  input  logic [dnle_pkg::BYTE_W-1:0]      nbr_byte,
  output logic [dnle_pkg::BYTE_W-1:0]      cell_byte
);
  import dnle_pkg::*;

  logic [BYTE_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_idx == idx)) begin
      data_r <= ctl.wr_char;
    end else if (ctl.shift) begin
      data_r <= nbr_byte;
    end
  end

  assign cell_byte = data_r;

endmodule

// File: design/dnle_ctrl.sv
`timescale 1ns / 1ps
// Controller: name parsing, limit checks, label flush sequencing and output word register.
// Drives the cell chain through chain_ctl_t. Uses dnle_pkg.
module dnle_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [dnle_pkg::BYTE_W-1:0]      in_name_char,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dnle_pkg::BYTE_W-1:0]      out_wire_byte,
  output logic                             out_root_follows,
  output logic                             out_last,
  output logic                             out_status,
  input  logic [dnle_pkg::BYTE_W-1:0]      head_byte,
  output dnle_pkg::chain_ctl_t             ctl
);
  import dnle_pkg::*;

  localparam logic [LEN_W:0] LABEL_LIMIT_X = (LEN_W + 1)'(LABEL_LIMIT);
  localparam logic [SUM_W-1:0] NAME_LIMIT_X = SUM_W'(NAME_LIMIT);

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [WIRE_W-1:0] wire_r, wire_nxt;
  logic              lone_r, lone_nxt;
  logic              seen_r, seen_nxt;
  logic              failed_r, failed_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              closing_r, closing_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_rf_r, out_rf_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_status_r, out_status_nxt;

  logic load, acc, is_end, is_dot, len_zero, data_done;
  logic do_err, do_flush, do_root, do_write, do_lone;
  logic [SUM_W-1:0] sum_close, sum_dot, sum_root;
  logic [LEN_W:0]   len_inc;

  assign load      = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !load;
  assign acc       = in_valid && !in_stall;
  assign is_end    = (opcode_t'(in_opcode) == OP_END);
  assign is_dot    = (in_name_char == DOT_CHAR);
  assign len_zero  = (len_r == '0);
  assign data_done = (rem_r == LEN_W'(1));
  assign sum_close = SUM_W'(wire_r) + SUM_W'(len_r) + SUM_W'(2);
  assign sum_dot   = SUM_W'(wire_r) + SUM_W'(len_r) + SUM_W'(1);
  assign sum_root  = SUM_W'(wire_r) + SUM_W'(1);
  assign len_inc   = {1'b0, len_r} + (LEN_W + 1)'(1);

  // item decode
  always_comb begin
    do_err   = 1'b0;
    do_flush = 1'b0;
    do_root  = 1'b0;
    do_write = 1'b0;
    do_lone  = 1'b0;
    if (!failed_r) begin
      if (is_end) begin
        if (!seen_r) begin
          do_err = 1'b1;
        end else if (!len_zero) begin
          if (sum_close > NAME_LIMIT_X) begin
            do_err = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end else if (sum_root > NAME_LIMIT_X) begin
          do_err = 1'b1;
        end else begin
          do_root = 1'b1;
        end
      end else if (lone_r) begin
        do_err = 1'b1;
      end else if (is_dot) begin
        if (len_zero) begin
          do_lone = 1'b1;
        end else if (sum_dot > NAME_LIMIT_X) begin
          do_err = 1'b1;
        end else begin
          do_flush = 1'b1;
        end
      end else if (len_inc >= LABEL_LIMIT_X) begin
        do_err = 1'b1;
      end else begin
        do_write = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && do_flush) begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (load && data_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    len_nxt        = len_r;
    wire_nxt       = wire_r;
    lone_nxt       = lone_r;
    seen_nxt       = seen_r;
    failed_nxt     = failed_r;
    rem_nxt        = rem_r;
    closing_nxt    = closing_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_rf_nxt     = out_rf_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    ctl.wr_en      = 1'b0;
    ctl.wr_idx     = len_r;
    ctl.wr_char    = in_name_char;
    ctl.shift      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (do_err) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = '0;
            out_rf_nxt     = 1'b0;
            out_last_nxt   = 1'b1;
            out_status_nxt = 1'b1;
          end else if (do_root) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = '0;
            out_rf_nxt     = 1'b0;
            out_last_nxt   = 1'b1;
            out_status_nxt = 1'b0;
          end else if (do_flush) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = BYTE_W'(len_r);
            out_rf_nxt     = 1'b0;
            out_last_nxt   = 1'b0;
            out_status_nxt = 1'b0;
            rem_nxt        = len_r;
            closing_nxt    = is_end;
          end
          if (is_end) begin
            len_nxt    = '0;
            wire_nxt   = '0;
            lone_nxt   = 1'b0;
            seen_nxt   = 1'b0;
            failed_nxt = 1'b0;
          end else if (!failed_r) begin
            seen_nxt = 1'b1;
            if (do_err) begin
              failed_nxt = 1'b1;
            end else if (do_lone) begin
              lone_nxt = 1'b1;
            end else if (do_flush) begin
              len_nxt  = '0;
              wire_nxt = WIRE_W'(sum_dot);
            end else if (do_write) begin
              ctl.wr_en = 1'b1;
              len_nxt   = len_inc[LEN_W-1:0];
            end
          end
        end
      end
      ST_DATA: begin
        if (load) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = head_byte;
          out_rf_nxt     = closing_r && data_done;
          out_last_nxt   = closing_r && data_done;
          out_status_nxt = 1'b0;
          ctl.shift      = 1'b1;
          rem_nxt        = rem_r - LEN_W'(1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      wire_r      <= '0;
      lone_r      <= 1'b0;
      seen_r      <= 1'b0;
      failed_r    <= 1'b0;
      rem_r       <= '0;
      closing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      wire_r      <= wire_nxt;
      lone_r      <= lone_nxt;
      seen_r      <= seen_nxt;
      failed_r    <= failed_nxt;
      rem_r       <= rem_nxt;
      closing_r   <= closing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_rf_r     <= out_rf_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_wire_byte    = out_byte_r;
  assign out_root_follows = out_rf_r;
  assign out_last         = out_last_r;
  assign out_status       = out_status_r;

endmodule

// File: design/dns_name_label_encoder.sv
`timescale 1ns / 1ps
// DNS name label encoder top level: controller plus a chain of label cells.
// Each result word is registered and appears in the cycle after its causing word is accepted.
// Throughput while out_stall is low: one input word per cycle; a flush of an n-character label
// sends n+1 words, its length and then its characters from the head of the cell chain, one per
// cycle, and input stalls during that burst. Synchronous active-low reset clears all control
// state and the output valid; label cells are not cleared. Uses dnle_pkg, dnle_ctrl, dnle_cell.
module dns_name_label_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [dnle_pkg::BYTE_W-1:0]      in_name_char,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dnle_pkg::BYTE_W-1:0]      out_wire_byte,
  output logic                             out_root_follows,
  output logic                             out_last,
  output logic                             out_status
);
  import dnle_pkg::*;

  chain_ctl_t        ctl;
  logic [BYTE_W-1:0] cell_q [CELLS];
  logic [BYTE_W-1:0] nbr_q  [CELLS];

  dnle_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_name_char     (in_name_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_wire_byte    (out_wire_byte),
    .out_root_follows (out_root_follows),
    .out_last         (out_last),
    .out_status       (out_status),
    .head_byte        (cell_q[0]),
    .ctl              (ctl)
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == CELLS - 1) begin : g_tail
      assign nbr_q[i] = '0;
    end else begin : g_mid
      assign nbr_q[i] = cell_q[i+1];
    end
    dnle_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (LEN_W'(i)),
      .nbr_byte  (nbr_q[i]),
      .cell_byte (cell_q[i])
    );
  end

endmodule
